@@ rtl/core/bgrg_pkg.sv @@
// Package with shared types, constants and glyph ROM functions of the rectangle generator.
`timescale 1ns / 1ps
package bgrg_pkg;

   localparam int unsigned QueueDepth = 2;

   localparam logic [20:0] BoxFirst = 21'h2500;
   localparam logic [20:0] BoxLast  = 21'h257F;
   localparam logic [20:0] BlkFirst = 21'h2580;
   localparam logic [20:0] BlkLast  = 21'h259F;

   localparam logic [2:0] BoldReset = 3'd1;

   // Fraction codes of the line ROM.
   localparam logic [2:0] FracZero = 3'd0;
   localparam logic [2:0] FracLow  = 3'd1;
   localparam logic [2:0] FracHalf = 3'd2;
   localparam logic [2:0] FracHigh = 3'd3;
   localparam logic [2:0] FracOne  = 3'd4;

   typedef enum logic [1:0] {
      CLASS_UNHANDLED = 2'd0,
      CLASS_BOX       = 2'd1,
      CLASS_BLOCK     = 2'd2,
      CLASS_CLEAR     = 2'd3
   } class_type;

   typedef struct packed {
      logic       vert;
      logic [2:0] x1;
      logic [2:0] y1;
      logic [2:0] x2;
      logic [2:0] y2;
   } prim_type;

   typedef struct packed {
      logic [2:0]    count;
      prim_type [3:0] prims;
   } box_entry_type;

   // Block rectangle in eighths of the cell (0..8).
   typedef struct packed {
      logic       valid;
      logic [3:0] x1;
      logic [3:0] y1;
      logic [3:0] x2;
      logic [3:0] y2;
   } blk_entry_type;

   // One classified item handed from front to back.
   typedef struct packed {
      class_type     cls;
      box_entry_type box;
      blk_entry_type blk;
      logic [12:0]   cell_x;
      logic [12:0]   cell_y;
      logic [7:0]    cell_width;
      logic [7:0]    cell_height;
   } work_type;

   typedef struct packed {
      logic        handled;
      logic        use_foreground;
      logic [13:0] rect_x;
      logic [13:0] rect_y;
      logic [7:0]  rect_w;
      logic [7:0]  rect_h;
      logic        last;
   } rsp_type;

   function automatic prim_type mk(input logic v, input logic [2:0] x1, input logic [2:0] y1,
                                   input logic [2:0] x2, input logic [2:0] y2);
      prim_type p;
      p.vert = v; p.x1 = x1; p.y1 = y1; p.x2 = x2; p.y2 = y2;
      return p;
   endfunction

   function automatic prim_type oh(input logic [2:0] y);
      return mk(1'b0, FracZero, y, FracOne, y);
   endfunction
   function automatic prim_type ohl(input logic [2:0] y);
      return mk(1'b0, FracZero, y, FracHalf, y);
   endfunction
   function automatic prim_type ohr(input logic [2:0] y);
      return mk(1'b0, FracHalf, y, FracOne, y);
   endfunction
   function automatic prim_type ov(input logic [2:0] x);
      return mk(1'b1, x, FracZero, x, FracOne);
   endfunction
   function automatic prim_type ovt(input logic [2:0] x);
      return mk(1'b1, x, FracZero, x, FracHalf);
   endfunction
   function automatic prim_type ovb(input logic [2:0] x);
      return mk(1'b1, x, FracHalf, x, FracOne);
   endfunction
   function automatic prim_type ovs(input logic [2:0] x, input logic [2:0] a,
                                    input logic [2:0] b);
      return mk(1'b1, x, a, x, b);
   endfunction

   function automatic box_entry_type ent(input logic [2:0] n, input prim_type p0,
                                         input prim_type p1, input prim_type p2,
                                         input prim_type p3);
      box_entry_type e;
      e.count = n;
      e.prims[0] = p0; e.prims[1] = p1; e.prims[2] = p2; e.prims[3] = p3;
      return e;
   endfunction

   function automatic box_entry_type box_rom(input logic [6:0] idx);
      prim_type z;
      box_entry_type e;
      z = '0;
      e = '0;
      if (idx <= 7'd1) e = ent(3'd1, oh(FracHalf), z, z, z);
      else if (idx <= 7'd3) e = ent(3'd1, ov(FracHalf), z, z, z);
      else if (idx <= 7'd11) e = '0;
      else if (idx <= 7'd15) e = ent(3'd2, ohr(FracHalf), ovb(FracHalf), z, z);
      else if (idx <= 7'd19) e = ent(3'd2, ohl(FracHalf), ovb(FracHalf), z, z);
      else if (idx <= 7'd23) e = ent(3'd2, ohr(FracHalf), ovt(FracHalf), z, z);
      else if (idx <= 7'd27) e = ent(3'd2, ohl(FracHalf), ovt(FracHalf), z, z);
      else if (idx <= 7'd35) e = ent(3'd2, ohr(FracHalf), ov(FracHalf), z, z);
      else if (idx <= 7'd43) e = ent(3'd2, ohl(FracHalf), ov(FracHalf), z, z);
      else if (idx <= 7'd51) e = ent(3'd2, oh(FracHalf), ovb(FracHalf), z, z);
      else if (idx <= 7'd59) e = ent(3'd2, oh(FracHalf), ovt(FracHalf), z, z);
      else if (idx <= 7'd75) e = ent(3'd2, oh(FracHalf), ov(FracHalf), z, z);
      else if (idx <= 7'd79) e = '0;
      else if (idx >= 7'd109 && idx <= 7'd115) e = '0;
      else if (idx >= 7'd116) begin
         case (idx[1:0])
            2'd0: e = ent(3'd1, (idx >= 7'd124) ? oh(FracHalf) : ohl(FracHalf), z, z, z);
            2'd1: e = ent(3'd1, (idx >= 7'd124) ? ov(FracHalf) : ovt(FracHalf), z, z, z);
            2'd2: e = ent(3'd1, (idx >= 7'd124) ? oh(FracHalf) : ohr(FracHalf), z, z, z);
            default: e = ent(3'd1, (idx >= 7'd124) ? ov(FracHalf) : ovb(FracHalf), z, z, z);
         endcase
      end else begin
         case (idx)
            7'd80: e = ent(3'd2, oh(FracLow), oh(FracHigh), z, z);
            7'd81: e = ent(3'd2, ov(FracLow), ov(FracHigh), z, z);
            7'd82: e = ent(3'd3, ohr(FracLow), ohr(FracHigh), ovb(FracHalf), z);
            7'd83: e = ent(3'd3, ohr(FracHalf), ovs(FracLow, FracHalf, FracOne),
                           ovs(FracHigh, FracHalf, FracOne), z);
            7'd84: e = ent(3'd4, ohr(FracLow), ohr(FracHigh), ovs(FracLow, FracLow, FracOne),
                           ovs(FracHigh, FracHigh, FracOne));
            7'd85: e = ent(3'd3, ohl(FracLow), ohl(FracHigh), ovb(FracHalf), z);
            7'd86: e = ent(3'd3, ohl(FracHalf), ovs(FracLow, FracHalf, FracOne),
                           ovs(FracHigh, FracHalf, FracOne), z);
            7'd87: e = ent(3'd4, ohl(FracLow), ohl(FracHigh), ovs(FracLow, FracLow, FracOne),
                           ovs(FracHigh, FracHigh, FracOne));
            7'd88: e = ent(3'd3, ohr(FracLow), ohr(FracHigh), ovt(FracHalf), z);
            7'd89: e = ent(3'd3, ohr(FracHalf), ovs(FracLow, FracZero, FracHalf),
                           ovs(FracHigh, FracZero, FracHalf), z);
            7'd90: e = ent(3'd4, ohr(FracLow), ohr(FracHigh), ovs(FracLow, FracZero, FracHigh),
                           ovs(FracHigh, FracZero, FracLow));
            7'd91: e = ent(3'd3, ohl(FracLow), ohl(FracHigh), ovt(FracHalf), z);
            7'd92: e = ent(3'd3, ohl(FracHalf), ovs(FracLow, FracZero, FracHalf),
                           ovs(FracHigh, FracZero, FracHalf), z);
            7'd93: e = ent(3'd4, ohl(FracLow), ohl(FracHigh), ovs(FracLow, FracZero, FracHigh),
                           ovs(FracHigh, FracZero, FracLow));
            7'd94: e = ent(3'd3, ohr(FracHalf), ov(FracLow), ov(FracHigh), z);
            7'd95: e = ent(3'd3, ohr(FracLow), ohr(FracHigh), ov(FracHalf), z);
            7'd96: e = ent(3'd4, ohr(FracLow), ohr(FracHigh), ov(FracLow), ov(FracHigh));
            7'd97: e = ent(3'd3, ohl(FracHalf), ov(FracLow), ov(FracHigh), z);
            7'd98: e = ent(3'd3, ohl(FracLow), ohl(FracHigh), ov(FracHalf), z);
            7'd99: e = ent(3'd4, ohl(FracLow), ohl(FracHigh), ov(FracLow), ov(FracHigh));
            7'd100: e = ent(3'd3, oh(FracLow), oh(FracHigh), ovb(FracHalf), z);
            7'd101: e = ent(3'd3, oh(FracHalf), ovs(FracLow, FracHalf, FracOne),
                            ovs(FracHigh, FracHalf, FracOne), z);
            7'd102: e = ent(3'd4, oh(FracLow), oh(FracHigh), ovs(FracLow, FracHigh, FracOne),
                            ovs(FracHigh, FracHigh, FracOne));
            7'd103: e = ent(3'd3, oh(FracLow), oh(FracHigh), ovt(FracHalf), z);
            7'd104: e = ent(3'd3, oh(FracHalf), ovs(FracLow, FracZero, FracHalf),
                            ovs(FracHigh, FracZero, FracHalf), z);
            7'd105: e = ent(3'd4, oh(FracLow), oh(FracHigh), ovs(FracLow, FracZero, FracLow),
                            ovs(FracHigh, FracZero, FracLow));
            7'd106: e = ent(3'd3, oh(FracLow), oh(FracHigh), ov(FracHalf), z);
            7'd107: e = ent(3'd3, oh(FracHalf), ov(FracLow), ov(FracHigh), z);
            7'd108: e = ent(3'd4, oh(FracLow), oh(FracHigh), ov(FracLow), ov(FracHigh));
            default: e = '0;
         endcase
      end
      return e;
   endfunction

   function automatic blk_entry_type bk(input logic [3:0] x1, input logic [3:0] y1,
                                        input logic [3:0] x2, input logic [3:0] y2);
      blk_entry_type b;
      b.valid = 1'b1; b.x1 = x1; b.y1 = y1; b.x2 = x2; b.y2 = y2;
      return b;
   endfunction

   // Entries with valid clear are shades and multi-part blocks.
   function automatic blk_entry_type blk_rom(input logic [4:0] idx);
      blk_entry_type b;
      case (idx)
         5'd0:  b = bk(4'd0, 4'd0, 4'd8, 4'd4);
         5'd1:  b = bk(4'd0, 4'd7, 4'd8, 4'd8);
         5'd2:  b = bk(4'd0, 4'd6, 4'd8, 4'd8);
         5'd3:  b = bk(4'd0, 4'd5, 4'd8, 4'd8);
         5'd4:  b = bk(4'd0, 4'd4, 4'd8, 4'd8);
         5'd5:  b = bk(4'd0, 4'd3, 4'd8, 4'd8);
         5'd6:  b = bk(4'd0, 4'd2, 4'd8, 4'd8);
         5'd7:  b = bk(4'd0, 4'd1, 4'd8, 4'd8);
         5'd8:  b = bk(4'd0, 4'd0, 4'd8, 4'd8);
         5'd9:  b = bk(4'd0, 4'd0, 4'd7, 4'd8);
         5'd10: b = bk(4'd0, 4'd0, 4'd6, 4'd8);
         5'd11: b = bk(4'd0, 4'd0, 4'd5, 4'd8);
         5'd12: b = bk(4'd0, 4'd0, 4'd4, 4'd8);
         5'd13: b = bk(4'd0, 4'd0, 4'd3, 4'd8);
         5'd14: b = bk(4'd0, 4'd0, 4'd2, 4'd8);
         5'd15: b = bk(4'd0, 4'd0, 4'd1, 4'd8);
         5'd16: b = bk(4'd4, 4'd0, 4'd8, 4'd8);
         5'd20: b = bk(4'd0, 4'd0, 4'd8, 4'd1);
         5'd21: b = bk(4'd7, 4'd0, 4'd8, 4'd8);
         5'd22: b = bk(4'd0, 4'd4, 4'd4, 4'd8);
         5'd23: b = bk(4'd4, 4'd4, 4'd8, 4'd8);
         5'd24: b = bk(4'd0, 4'd0, 4'd4, 4'd4);
         5'd29: b = bk(4'd4, 4'd0, 4'd8, 4'd4);
         default: b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [16:0] frac_q16(input logic [2:0] f);
      logic [16:0] q;
      case (f)
         FracZero: q = 17'd0;
         FracLow:  q = 17'd22938;
         FracHalf: q = 17'd32768;
         FracHigh: q = 17'd42598;
         FracOne:  q = 17'd65536;
         default:  q = 17'd0;
      endcase
      return q;
   endfunction

   // (frac * size) >> 16 with an 17 by 8 bit product.
   function automatic logic [7:0] scale(input logic [16:0] frac, input logic [7:0] size);
      logic [24:0] p;
      p = frac * size;
      return p[23:16];
   endfunction

   // Block edge in eighths: (k * 8192 * size) >> 16 equals (k * size) >> 3.
   function automatic logic [7:0] scale8(input logic [3:0] k, input logic [7:0] size);
      logic [11:0] p;
      p = k * size;
      return p[10:3];
   endfunction

endpackage

@@ rtl/core/bgrg_stream_if.sv @@
// Valid/ready channel interfaces for the rectangle generator.
`timescale 1ns / 1ps
interface bgrg_req_if;
   logic        valid;
   logic        ready;
   logic [20:0] char_code;
   logic [12:0] cell_x;
   logic [12:0] cell_y;
   logic [7:0]  cell_width;
   logic [7:0]  cell_height;
   modport source (output valid, char_code, cell_x, cell_y, cell_width, cell_height,
                   input ready);
   modport sink   (input valid, char_code, cell_x, cell_y, cell_width, cell_height,
                   output ready);
endinterface

interface bgrg_rsp_if;
   logic        valid;
   logic        ready;
   logic        handled;
   logic        use_foreground;
   logic [13:0] rect_x;
   logic [13:0] rect_y;
   logic [7:0]  rect_w;
   logic [7:0]  rect_h;
   logic        last;
   modport source (output valid, handled, use_foreground, rect_x, rect_y, rect_w, rect_h,
                   last, input ready);
   modport sink   (input valid, handled, use_foreground, rect_x, rect_y, rect_w, rect_h,
                   last, output ready);
endinterface

interface bgrg_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/bgrg_front.sv @@
// Front end: classifies each cell and looks up its glyph ROM entry.
`timescale 1ns / 1ps
module bgrg_front (
   input  logic              clock,
   input  logic              reset,
   bgrg_req_if.sink          req,
   output bgrg_pkg::work_type work_out,
   output logic              work_valid,
   input  logic              work_ready
);
   import bgrg_pkg::*;

   logic     valid_ff, valid_in;
   work_type work_ff, work_in;
   logic [6:0] box_idx;
   logic [4:0] blk_idx;

   assign req.ready = !valid_ff || work_ready;
   assign box_idx = 7'(req.char_code - BoxFirst);
   assign blk_idx = 5'(req.char_code - BlkFirst);

   always_comb begin
      work_in.box = box_rom(box_idx);
      work_in.blk = blk_rom(blk_idx);
      work_in.cell_x = req.cell_x;
      work_in.cell_y = req.cell_y;
      work_in.cell_width = req.cell_width;
      work_in.cell_height = req.cell_height;
      if (req.char_code >= BoxFirst && req.char_code <= BoxLast) begin
         work_in.cls = (work_in.box.count == 3'd0) ? CLASS_UNHANDLED : CLASS_BOX;
      end else if (req.char_code >= BlkFirst && req.char_code <= BlkLast) begin
         if (!work_in.blk.valid) work_in.cls = CLASS_UNHANDLED;
         else if (scale8(work_in.blk.x2 - work_in.blk.x1, req.cell_width) == 8'd0 ||
                  scale8(work_in.blk.y2 - work_in.blk.y1, req.cell_height) == 8'd0)
            work_in.cls = CLASS_CLEAR;
         else work_in.cls = CLASS_BLOCK;
      end else begin
         work_in.cls = CLASS_UNHANDLED;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (req.ready) valid_in = req.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (req.valid && req.ready) work_ff <= work_in;
   end

   assign work_out = work_ff;
   assign work_valid = valid_ff;
endmodule

@@ rtl/core/bgrg_queue.sv @@
// Short queue between the classifying front end and the rectangle back end.
`timescale 1ns / 1ps
module bgrg_queue #(
   parameter int unsigned Depth = bgrg_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  bgrg_pkg::work_type in_data,
   input  logic               in_valid,
   output logic               in_ready,
   output bgrg_pkg::work_type out_data,
   output logic               out_valid,
   input  logic               out_ready
);
   import bgrg_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

   work_type            mem [Depth];
   logic [PtrW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]       cnt_ff, cnt_in;
   logic                push, pop;

   assign in_ready = cnt_ff != (PtrW+1)'(Depth);
   assign out_valid = cnt_ff != '0;
   assign out_data = mem[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      if (pop) rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem[wr_ff] <= in_data;
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PtrW+1)'(Depth))
      else $error("queue count above depth");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count missed a push");
   assert property (@(posedge clock) disable iff (reset)
      !push && pop |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("queue count missed a pop");
endmodule

@@ rtl/core/bgrg_back.sv @@
// Back end: walks the primitives of one cell and emits one rectangle per beat.
`timescale 1ns / 1ps
module bgrg_back (
   input  logic               clock,
   input  logic               reset,
   input  bgrg_pkg::work_type work_in_data,
   input  logic               work_valid,
   output logic               work_ready,
   input  logic [2:0]         bold_extra,
   bgrg_rsp_if.source         rsp
);
   import bgrg_pkg::*;

   // Step 0 is the background clear; step k is box primitive k-1, and step 1 is the block rectangle.
   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in;
   logic       load, final_step;
   prim_type   p;
   logic [7:0] x1, y1, x2, y2, thick, bx, by, bw, bh;
   work_type   w;

   assign w = work_in_data;
   assign load = work_valid && (!valid_ff || rsp.ready);
   assign p = w.box.prims[2'(step_ff - 3'd1)];
   assign thick = 8'd1 + 8'(bold_extra);

   always_comb begin
      x1 = scale(frac_q16(p.x1), w.cell_width);
      y1 = scale(frac_q16(p.y1), w.cell_height);
      x2 = scale(frac_q16(p.x2), w.cell_width);
      y2 = scale(frac_q16(p.y2), w.cell_height);
      bx = scale8(w.blk.x1, w.cell_width);
      by = scale8(w.blk.y1, w.cell_height);
      bw = scale8(w.blk.x2 - w.blk.x1, w.cell_width);
      bh = scale8(w.blk.y2 - w.blk.y1, w.cell_height);
      out_in = '0;
      out_in.handled = 1'b1;
      out_in.rect_x = {1'b0, w.cell_x};
      out_in.rect_y = {1'b0, w.cell_y};
      out_in.rect_w = w.cell_width;
      out_in.rect_h = w.cell_height;
      final_step = 1'b0;
      case (w.cls)
         CLASS_UNHANDLED: begin
            out_in = '0;
            final_step = 1'b1;
         end
         CLASS_CLEAR: final_step = 1'b1;
         CLASS_BLOCK: begin
            final_step = step_ff == 3'd1;
            if (step_ff != 3'd0) begin
               out_in.use_foreground = 1'b1;
               out_in.rect_x = {1'b0, w.cell_x} + 14'(bx);
               out_in.rect_y = {1'b0, w.cell_y} + 14'(by);
               out_in.rect_w = bw;
               out_in.rect_h = bh;
            end
         end
         CLASS_BOX: begin
            final_step = step_ff == w.box.count;
            if (step_ff != 3'd0) begin
               out_in.use_foreground = 1'b1;
               out_in.rect_x = {1'b0, w.cell_x} + 14'(x1);
               out_in.rect_y = {1'b0, w.cell_y} + 14'(y1);
               out_in.rect_w = p.vert ? thick : x2 - x1;
               out_in.rect_h = p.vert ? y2 - y1 : thick;
            end
         end
         default: final_step = 1'b1;
      endcase
      out_in.last = final_step;
   end

   assign work_ready = load && final_step;

   always_comb begin
      step_in = step_ff;
      valid_in = valid_ff && !rsp.ready;
      if (load) begin
         valid_in = 1'b1;
         step_in = final_step ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         valid_ff <= valid_in;
      end
      if (load) out_ff <= out_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.handled = out_ff.handled;
   assign rsp.use_foreground = out_ff.use_foreground;
   assign rsp.rect_x = out_ff.rect_x;
   assign rsp.rect_y = out_ff.rect_y;
   assign rsp.rect_w = out_ff.rect_w;
   assign rsp.rect_h = out_ff.rect_h;
   assign rsp.last = out_ff.last;

   assert property (@(posedge clock) disable iff (reset)
      step_ff <= 3'd4)
      else $error("step counter past four primitives");
   assert property (@(posedge clock) disable iff (reset)
      work_ready |-> work_valid)
      else $error("item retired without one queued");
   assert property (@(posedge clock) disable iff (reset)
      load && !final_step |=> step_ff == $past(step_ff) + 3'd1)
      else $error("step counter skipped a primitive");
endmodule

@@ rtl/core/box_glyph_rect_generator.sv @@
// Top level of the box and block glyph rectangle generator.
// A request is held in the front-end register, the queue and the output register in turn.
// One rectangle beat per cycle when not stalled; a cell gives 1 to 5 (1 + primitives).
// The request side runs ahead of the rectangle walker through a two-entry queue.
// Reset is synchronous and active high; it empties all stages and sets bold_extra to 1.
`timescale 1ns / 1ps
module box_glyph_rect_generator #(
   parameter int unsigned QDepth = bgrg_pkg::QueueDepth
) (
   input logic clock,
   input logic reset,
   bgrg_req_if.sink   req,
   bgrg_rsp_if.source rsp,
   bgrg_csr_if.sink   csr
);
   import bgrg_pkg::*;

   logic [2:0] bold_ff;
   work_type   f_data, q_data;
   logic       f_valid, f_ready, q_valid, q_ready;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) bold_ff <= BoldReset;
      else if (csr.valid) bold_ff <= csr.data;
   end

   bgrg_front u_front (.clock, .reset, .req, .work_out(f_data), .work_valid(f_valid),
                       .work_ready(f_ready));

   bgrg_queue #(.Depth(QDepth)) u_queue (.clock, .reset, .in_data(f_data),
      .in_valid(f_valid), .in_ready(f_ready), .out_data(q_data), .out_valid(q_valid),
      .out_ready(q_ready));

   bgrg_back u_back (.clock, .reset, .work_in_data(q_data), .work_valid(q_valid),
                     .work_ready(q_ready), .bold_extra(bold_ff), .rsp);
endmodule
